// File: hdl/rha_pkg.sv
// ----------------------------------------------------------------------------
// rha_pkg: shared types and constants for the region heap allocator
// Region geometry, status codes, command kinds and the mask bit helper.
// ----------------------------------------------------------------------------
package rha_pkg;

    // Heap geometry; region size is a power of two
    localparam int REGION_COUNT  = 24;
    localparam int REGION_SHIFT  = 10;
    localparam int REGION_BYTES  = 1 << REGION_SHIFT;
    localparam int MASK_BIT_BASE = 4;

    localparam int IDX_W  = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
    localparam int RUN_W  = 5;
    localparam int NEED_W = 17 - REGION_SHIFT;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ALLOC_FAIL = 2'd1;
    localparam logic [1:0] ST_BAD_FREE   = 2'd2;

    // Request kind after classification
    typedef enum logic [1:0] {
        K_ALLOC  = 2'd0,
        K_FREE   = 2'd1,
        K_REJECT = 2'd2
    } t_kind;

    // Command passed from front to back
    typedef struct packed {
        t_kind             kind;
        logic [7:0]        owner;
        logic [RUN_W-1:0]  need;
        logic [15:0]       offset;
    } t_cmd;

    // One-hot grant bit of a region, zero when it falls past bit 31
    function automatic logic [31:0] region_bit(input logic [IDX_W-1:0] idx);
        logic [6:0] b;
        b = 7'(MASK_BIT_BASE) + 7'(idx);
        return (b < 7'd32) ? (32'd1 << b[4:0]) : 32'd0;
    endfunction

    // Byte offset of a region, low 16 bits
    function automatic logic [15:0] region_offset(input logic [IDX_W-1:0] idx);
        logic [31:0] o;
        o = 32'(idx) << REGION_SHIFT;
        return o[15:0];
    endfunction

endpackage

// File: hdl/rha_front.sv
// ----------------------------------------------------------------------------
// rha_front: request classifier
// Turns an input item into a command: region count for allocations, and
// rejection of zero size, owner zero and oversize requests.
// ----------------------------------------------------------------------------
module rha_front import rha_pkg::*; (
    input  logic        i_op,
    input  logic [7:0]  i_owner_id,
    input  logic [15:0] i_alloc_bytes,
    input  logic [15:0] i_free_offset,
    output t_cmd        o_cmd
);

    logic [15:0]       bytes_m1;
    logic [NEED_W-1:0] need;
    logic              reject;

    // Compute regions needed: (bytes - 1) / REGION_BYTES + 1
    assign bytes_m1 = i_alloc_bytes - 16'd1;
    assign need     = NEED_W'(bytes_m1 >> REGION_SHIFT) + NEED_W'(1);

    assign reject = (i_alloc_bytes == 16'd0) || (i_owner_id == 8'd0)
                 || (32'(need) > 32'(REGION_COUNT));

    // Build the command
    always_comb begin
        o_cmd.owner  = i_owner_id;
        o_cmd.need   = RUN_W'(need);
        o_cmd.offset = i_free_offset;
        if (i_op) begin
            o_cmd.kind = K_FREE;
        end else if (reject) begin
            o_cmd.kind = K_REJECT;
        end else begin
            o_cmd.kind = K_ALLOC;
        end
    end

endmodule

// File: hdl/rha_queue.sv
// ----------------------------------------------------------------------------
// rha_queue: two-entry command queue
// Decouples the classifier from the sequencer so each side stalls alone.
// ----------------------------------------------------------------------------
module rha_queue import rha_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = do_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store pushed command
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: hdl/rha_back.sv
// ----------------------------------------------------------------------------
// rha_back: allocation sequencer
// Walks the region table one entry a cycle for first-fit search, fill,
// free lookup and clear, and holds the result in an output register.
// ----------------------------------------------------------------------------
module rha_back import rha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_base_offset,
    output logic [31:0] o_access_mask
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_FILL  = 6'b000100,
        S_FIND  = 6'b001000,
        S_CLEAR = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REGION_COUNT - 1);

    t_state           r_state, n_state;
    logic [7:0]       r_owner_tab [REGION_COUNT];
    logic [RUN_W-1:0] r_run_tab   [REGION_COUNT];
    logic [31:0]      r_grant, n_grant;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_base, n_base;
    logic [RUN_W-1:0] r_cnt, n_cnt;
    logic [RUN_W-1:0] r_left, n_left;
    logic [RUN_W-1:0] r_need, n_need;
    logic [7:0]       r_owner, n_owner;
    logic [15:0]      r_offset, n_offset;
    logic [1:0]       r_res_status, n_res_status;
    logic [15:0]      r_res_base, n_res_base;
    logic             r_out_valid, n_out_valid;
    logic [1:0]       r_status;
    logic [15:0]      r_base_offset;
    logic [31:0]      r_access_mask;

    logic             tab_we;
    logic [7:0]       tab_owner;
    logic [RUN_W-1:0] tab_run;
    logic [7:0]       cur_owner;
    logic [RUN_W-1:0] cur_run;
    logic [RUN_W-1:0] cnt_inc;
    logic             out_load;

    assign cur_owner = r_owner_tab[r_idx];
    assign cur_run   = r_run_tab[r_idx];
    assign cnt_inc   = r_cnt + RUN_W'(1);
    assign out_load  = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign o_pop     = (r_state == S_IDLE) && !i_empty;

    // Sequence one command
    always_comb begin
        n_state      = r_state;
        n_grant      = r_grant;
        n_idx        = r_idx;
        n_base       = r_base;
        n_cnt        = r_cnt;
        n_left       = r_left;
        n_need       = r_need;
        n_owner      = r_owner;
        n_offset     = r_offset;
        n_res_status = r_res_status;
        n_res_base   = r_res_base;
        tab_we       = 1'b0;
        tab_owner    = 8'd0;
        tab_run      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_idx        = '0;
                    n_cnt        = '0;
                    n_need       = i_cmd.need;
                    n_owner      = i_cmd.owner;
                    n_offset     = i_cmd.offset;
                    n_res_base   = 16'd0;
                    unique case (i_cmd.kind)
                        K_ALLOC: n_state = S_SCAN;
                        K_FREE:  n_state = S_FIND;
                        default: begin
                            n_res_status = ST_ALLOC_FAIL;
                            n_state      = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Count free regions in a row until the run covers the need
                if (cur_owner == 8'd0 && cnt_inc == r_need) begin
                    n_base  = IDX_W'(r_idx + IDX_W'(1) - IDX_W'(r_need));
                    n_idx   = IDX_W'(r_idx + IDX_W'(1) - IDX_W'(r_need));
                    n_left  = r_need;
                    n_state = S_FILL;
                end else if (r_idx == LAST_IDX) begin
                    n_res_status = ST_ALLOC_FAIL;
                    n_state      = S_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                    n_cnt = (cur_owner == 8'd0) ? cnt_inc : '0;
                end
            end
            S_FILL: begin
                // Claim one region of the run
                tab_we    = 1'b1;
                tab_owner = r_owner;
                tab_run   = (r_idx == r_base) ? r_need : '0;
                n_grant   = r_grant | region_bit(r_idx);
                n_left    = r_left - RUN_W'(1);
                if (r_left == RUN_W'(1)) begin
                    n_res_status = ST_OK;
                    n_res_base   = region_offset(r_base);
                    n_state      = S_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_FIND: begin
                // Look for a run base held by this owner at the offset
                if (cur_run != '0 && cur_owner == r_owner
                        && region_offset(r_idx) == r_offset) begin
                    n_left  = cur_run;
                    n_state = S_CLEAR;
                end else if (r_idx == LAST_IDX) begin
                    n_res_status = ST_BAD_FREE;
                    n_state      = S_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_CLEAR: begin
                // Release one region of the run
                tab_we    = 1'b1;
                tab_owner = 8'd0;
                tab_run   = '0;
                n_grant   = r_grant & ~region_bit(r_idx);
                n_left    = r_left - RUN_W'(1);
                if (r_left == RUN_W'(1) || r_idx == LAST_IDX) begin
                    n_res_status = ST_OK;
                    n_state      = S_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold the result until taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_grant     <= 32'd0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < REGION_COUNT; i++) begin
                r_owner_tab[i] <= 8'd0;
                r_run_tab[i]   <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_grant     <= n_grant;
            r_out_valid <= n_out_valid;
            if (tab_we) begin
                r_owner_tab[r_idx] <= tab_owner;
                r_run_tab[r_idx]   <= tab_run;
            end
        end
    end

    // Working and result payload
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_base       <= n_base;
        r_cnt        <= n_cnt;
        r_left       <= n_left;
        r_need       <= n_need;
        r_owner      <= n_owner;
        r_offset     <= n_offset;
        r_res_status <= n_res_status;
        r_res_base   <= n_res_base;
        if (out_load) begin
            r_status      <= r_res_status;
            r_base_offset <= r_res_base;
            r_access_mask <= r_grant;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_base_offset = r_base_offset;
    assign o_access_mask = r_access_mask;

endmodule

// File: hdl/region_heap_allocator_core.sv
// A rejected allocation goes from idle straight to the result state; an
// allocation scans the table for a free run, then fills each region of
// the run; a free looks up the run base, then clears each region of the
// run. The sequencer walks the region table for one item at a time and
// pops no new command until its result is loaded. Two queue entries
// buffer input. Synchronous active-low reset clears the table and grant mask.
// ----------------------------------------------------------------------------
// region_heap_allocator_core: first-fit region allocator top level
// Classifier, command queue and table sequencer in one channel path.
// ----------------------------------------------------------------------------
module region_heap_allocator_core import rha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [7:0]  i_owner_id,
    input  logic [15:0] i_alloc_bytes,
    input  logic [15:0] i_free_offset,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_base_offset,
    output logic [31:0] o_access_mask
);

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic queue_full;
    logic queue_empty;
    logic queue_pop;

    // Classify the input item
    rha_front u_front (
        .i_op          (i_op),
        .i_owner_id    (i_owner_id),
        .i_alloc_bytes (i_alloc_bytes),
        .i_free_offset (i_free_offset),
        .o_cmd         (front_cmd)
    );

    // Buffer commands between front and back
    rha_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_empty (queue_empty),
        .o_cmd   (queue_cmd)
    );

    assign o_in_stall = queue_full;

    // Carry out commands on the region table
    rha_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (queue_empty),
        .i_cmd         (queue_cmd),
        .o_pop         (queue_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_base_offset (o_base_offset),
        .o_access_mask (o_access_mask)
    );

endmodule
